// File: rtl/core/assert_macros.svh
// Assertion helpers used by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BBVE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define BBVE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/bbve_pkg.sv
package bbve_pkg;

    localparam int BW_W     = 32;
    localparam int BUS_W    = 8;
    localparam int FACTOR_W = 16;
    localparam int UNIT_W   = 32;
    localparam int VOTE_W   = 14;
    localparam int PROD_W   = BW_W + FACTOR_W;      // bandwidth times factor
    localparam int SCALE_W  = 10;
    localparam int P2_W     = PROD_W + SCALE_W;     // after scaling by 1000
    localparam int WORD_W   = 31;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 32;

    localparam logic [SCALE_W-1:0] KBPS_SCALE = SCALE_W'(1000);
    localparam logic [VOTE_W-1:0]  VOTE_MAX   = {VOTE_W{1'b1}};
    localparam int COMMIT_BIT = 30;
    localparam int VALID_BIT  = 29;

    typedef struct packed {
        logic              vld;
        logic              commit;
        logic              bw_nz;
        logic              fault;
        logic              fixed;
        logic              sat;
        logic [VOTE_W-1:0] fvote;
    } ctrl_t;

endpackage

// File: rtl/core/bus_bandwidth_vote_encoder.sv
// Bus bandwidth vote encoder. Takes one request per cycle unless the result
// side stalls and returns one command word per request, in order. A request
// passes an input stage with the 32x16 bandwidth multiply, a row of 48 cells
// dividing by bus width one quotient bit each, a scaling stage (times 1000),
// a saturation stage, a row of 14 cells dividing by the vote unit, and the
// output register. The whole row advances together, so a stall on the result
// side holds it.
`include "assert_macros.svh"
module bus_bandwidth_vote_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] bandwidth, [39:32] bus bytes, [55:40] width_factor,
    // [87:56] vote_unit, [101:88] fixed_mode_vote,
    // [133:102] fixed_threshold_kbps, [135:134] zero
    input  logic [bbve_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,   // commit
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [30:0] command_word, [31] fault
    output logic [bbve_pkg::M_DATA_W-1:0]   m_tdata
);
    import bbve_pkg::*;

    localparam int N8  = PROD_W;
    localparam int N32 = VOTE_W;

    logic                 adv;
    logic [BW_W-1:0]      in_bw, in_thr;
    logic [BUS_W-1:0]     in_bus;
    logic [FACTOR_W-1:0]  in_factor;
    logic [UNIT_W-1:0]    in_unit;
    logic [VOTE_W-1:0]    in_fv;
    ctrl_t                in_ctrl;

    ctrl_t                mul_ctrl_reg;
    logic [PROD_W-1:0]    mul_prod_reg;
    logic [BUS_W-1:0]     mul_bus_reg;
    logic [UNIT_W-1:0]    mul_unit_reg;

    ctrl_t                c8   [0:N8];
    logic [BUS_W-1:0]     r8   [0:N8];
    logic [PROD_W-1:0]    q8   [0:N8];
    logic [BUS_W-1:0]     d8   [0:N8];
    logic [UNIT_W-1:0]    u8   [0:N8];

    ctrl_t                cm_reg;
    logic [P2_W-1:0]      p2_reg;
    logic [UNIT_W-1:0]    um_reg;
    ctrl_t                cs_next;

    ctrl_t                sat_ctrl_reg;
    logic [UNIT_W-1:0]    sat_rem_reg;
    logic [VOTE_W-1:0]    sat_qd_reg;
    logic [UNIT_W-1:0]    sat_unit_reg;

    ctrl_t                c32  [0:N32];
    logic [UNIT_W-1:0]    r32  [0:N32];
    logic [VOTE_W-1:0]    q32  [0:N32];
    logic [UNIT_W-1:0]    u32  [0:N32];

    ctrl_t                cf;
    logic [VOTE_W-1:0]    vote;
    logic [WORD_W-1:0]    word;
    logic                 out_vld_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        in_bw     = s_tdata[31:0];
        in_bus    = s_tdata[39:32];
        in_factor = s_tdata[55:40];
        in_unit   = s_tdata[87:56];
        in_fv     = s_tdata[101:88];
        in_thr    = s_tdata[133:102];
        in_ctrl.vld    = s_tvalid;
        in_ctrl.commit = s_tlast;
        in_ctrl.bw_nz  = in_bw != '0;
        in_ctrl.fixed  = in_fv != '0;
        in_ctrl.fault  = in_ctrl.bw_nz && !in_ctrl.fixed
                         && (in_unit == '0 || in_bus == '0);
        in_ctrl.sat    = 1'b0;
        in_ctrl.fvote  = (in_bw >= in_thr) ? in_fv : '0;
    end

    // input stage: multiply and classify
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_ctrl_reg.vld <= 1'b0;
        end else if (adv) begin
            mul_ctrl_reg.vld <= in_ctrl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_ctrl_reg.commit <= in_ctrl.commit;
            mul_ctrl_reg.bw_nz  <= in_ctrl.bw_nz;
            mul_ctrl_reg.fault  <= in_ctrl.fault;
            mul_ctrl_reg.fixed  <= in_ctrl.fixed;
            mul_ctrl_reg.sat    <= in_ctrl.sat;
            mul_ctrl_reg.fvote  <= in_ctrl.fvote;
            mul_prod_reg        <= PROD_W'(in_bw) * PROD_W'(in_factor);
            mul_bus_reg         <= in_bus;
            mul_unit_reg        <= in_unit;
        end
    end

    assign c8[0] = mul_ctrl_reg;
    assign r8[0] = '0;
    assign q8[0] = mul_prod_reg;
    assign d8[0] = mul_bus_reg;
    assign u8[0] = mul_unit_reg;

    for (genvar i = 0; i < N8; i++) begin : g_div8
        bbve_div8_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctrl_i  (c8[i]),
            .rem_i   (r8[i]),
            .qd_i    (q8[i]),
            .div_i   (d8[i]),
            .unit_i  (u8[i]),
            .ctrl_o  (c8[i+1]),
            .rem_o   (r8[i+1]),
            .qd_o    (q8[i+1]),
            .div_o   (d8[i+1]),
            .unit_o  (u8[i+1])
        );
    end

    // scale by 1000
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cm_reg.vld <= 1'b0;
        end else if (adv) begin
            cm_reg.vld <= c8[N8].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cm_reg.commit <= c8[N8].commit;
            cm_reg.bw_nz  <= c8[N8].bw_nz;
            cm_reg.fault  <= c8[N8].fault;
            cm_reg.fixed  <= c8[N8].fixed;
            cm_reg.sat    <= c8[N8].sat;
            cm_reg.fvote  <= c8[N8].fvote;
            p2_reg        <= P2_W'(q8[N8]) * P2_W'(KBPS_SCALE);
            um_reg        <= u8[N8];
        end
    end

    // flag a quotient above the vote range, then divide what is left
    always_comb begin
        cs_next     = cm_reg;
        cs_next.sat = p2_reg >= {P2_W'(um_reg), VOTE_W'(0)} >> 0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_ctrl_reg.vld <= 1'b0;
        end else if (adv) begin
            sat_ctrl_reg.vld <= cs_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sat_ctrl_reg.commit <= cs_next.commit;
            sat_ctrl_reg.bw_nz  <= cs_next.bw_nz;
            sat_ctrl_reg.fault  <= cs_next.fault;
            sat_ctrl_reg.fixed  <= cs_next.fixed;
            sat_ctrl_reg.sat    <= cs_next.sat;
            sat_ctrl_reg.fvote  <= cs_next.fvote;
            sat_rem_reg         <= p2_reg[VOTE_W +: UNIT_W];
            sat_qd_reg          <= p2_reg[VOTE_W-1:0];
            sat_unit_reg        <= um_reg;
        end
    end

    assign c32[0] = sat_ctrl_reg;
    assign r32[0] = sat_rem_reg;
    assign q32[0] = sat_qd_reg;
    assign u32[0] = sat_unit_reg;

    for (genvar j = 0; j < N32; j++) begin : g_div32
        bbve_div32_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .ctrl_i  (c32[j]),
            .rem_i   (r32[j]),
            .qd_i    (q32[j]),
            .unit_i  (u32[j]),
            .ctrl_o  (c32[j+1]),
            .rem_o   (r32[j+1]),
            .qd_o    (q32[j+1]),
            .unit_o  (u32[j+1])
        );
    end

    always_comb begin
        cf = c32[N32];
        if (!cf.bw_nz) begin
            vote = '0;
        end else if (cf.fixed) begin
            vote = cf.fvote;
        end else if (cf.sat) begin
            vote = VOTE_MAX;
        end else if (q32[N32] == '0) begin
            vote = VOTE_W'(1);
        end else begin
            vote = q32[N32];
        end
        word                 = '0;
        word[VOTE_W-1:0]     = vote;
        word[VOTE_W +: VOTE_W] = vote;
        word[VALID_BIT]      = cf.bw_nz;
        word[COMMIT_BIT]     = cf.commit;
        if (cf.fault) begin
            word = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= cf.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {cf.fault, word};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `BBVE_ASSERT(a_fault_clears_word, m_tvalid && m_tdata[WORD_W] |-> m_tdata[WORD_W-1:0] == '0, "fault word")
    `BBVE_ASSERT(a_off_no_vote, m_tvalid && !m_tdata[VALID_BIT] |-> m_tdata[2*VOTE_W-1:0] == '0, "off vote")
    `BBVE_ASSERT(a_vote_copies, m_tvalid |-> m_tdata[VOTE_W-1:0] == m_tdata[VOTE_W +: VOTE_W], "vote fields")
    `BBVE_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready), "ready rule")

endmodule

// File: rtl/core/bbve_div8_cell.sv
// One restoring step of the division by bus width.
module bbve_div8_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  bbve_pkg::ctrl_t                      ctrl_i,
    input  logic [bbve_pkg::BUS_W-1:0]           rem_i,
    input  logic [bbve_pkg::PROD_W-1:0]          qd_i,
    input  logic [bbve_pkg::BUS_W-1:0]           div_i,
    input  logic [bbve_pkg::UNIT_W-1:0]          unit_i,
    output bbve_pkg::ctrl_t                      ctrl_o,
    output logic [bbve_pkg::BUS_W-1:0]           rem_o,
    output logic [bbve_pkg::PROD_W-1:0]          qd_o,
    output logic [bbve_pkg::BUS_W-1:0]           div_o,
    output logic [bbve_pkg::UNIT_W-1:0]          unit_o
);
    import bbve_pkg::*;

    ctrl_t              ctrl_reg;
    logic [BUS_W-1:0]   rem_reg, rem_next;
    logic [PROD_W-1:0]  qd_reg, qd_next;
    logic [BUS_W-1:0]   div_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic [BUS_W:0]     trial;
    logic               ge;

    always_comb begin
        trial    = {rem_i, qd_i[PROD_W-1]};
        ge       = trial >= {1'b0, div_i};
        rem_next = ge ? BUS_W'(trial - {1'b0, div_i}) : trial[BUS_W-1:0];
        qd_next  = {qd_i[PROD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.vld <= 1'b0;
        end else if (en) begin
            ctrl_reg.vld <= ctrl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg.commit <= ctrl_i.commit;
            ctrl_reg.bw_nz  <= ctrl_i.bw_nz;
            ctrl_reg.fault  <= ctrl_i.fault;
            ctrl_reg.fixed  <= ctrl_i.fixed;
            ctrl_reg.sat    <= ctrl_i.sat;
            ctrl_reg.fvote  <= ctrl_i.fvote;
            rem_reg         <= rem_next;
            qd_reg          <= qd_next;
            div_reg         <= div_i;
            unit_reg        <= unit_i;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign rem_o  = rem_reg;
    assign qd_o   = qd_reg;
    assign div_o  = div_reg;
    assign unit_o = unit_reg;

endmodule

// File: rtl/core/bbve_div32_cell.sv
// One restoring step of the division by vote unit; the partial remainder
// stays below the unit for every request not flagged as saturated beforehand.
module bbve_div32_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  bbve_pkg::ctrl_t                      ctrl_i,
    input  logic [bbve_pkg::UNIT_W-1:0]          rem_i,
    input  logic [bbve_pkg::VOTE_W-1:0]          qd_i,
    input  logic [bbve_pkg::UNIT_W-1:0]          unit_i,
    output bbve_pkg::ctrl_t                      ctrl_o,
    output logic [bbve_pkg::UNIT_W-1:0]          rem_o,
    output logic [bbve_pkg::VOTE_W-1:0]          qd_o,
    output logic [bbve_pkg::UNIT_W-1:0]          unit_o
);
    import bbve_pkg::*;

    ctrl_t              ctrl_reg;
    logic [UNIT_W-1:0]  rem_reg, rem_next;
    logic [VOTE_W-1:0]  qd_reg, qd_next;
    logic [UNIT_W-1:0]  unit_reg;
    logic [UNIT_W:0]    trial;
    logic               ge;

    always_comb begin
        trial    = {rem_i, qd_i[VOTE_W-1]};
        ge       = trial >= {1'b0, unit_i};
        rem_next = ge ? UNIT_W'(trial - {1'b0, unit_i}) : trial[UNIT_W-1:0];
        qd_next  = {qd_i[VOTE_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.vld <= 1'b0;
        end else if (en) begin
            ctrl_reg.vld <= ctrl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg.commit <= ctrl_i.commit;
            ctrl_reg.bw_nz  <= ctrl_i.bw_nz;
            ctrl_reg.fault  <= ctrl_i.fault;
            ctrl_reg.fixed  <= ctrl_i.fixed;
            ctrl_reg.sat    <= ctrl_i.sat;
            ctrl_reg.fvote  <= ctrl_i.fvote;
            rem_reg         <= rem_next;
            qd_reg          <= qd_next;
            unit_reg        <= unit_i;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign rem_o  = rem_reg;
    assign qd_o   = qd_reg;
    assign unit_o = unit_reg;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import bbve_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 1430;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [31:0] bw;
        logic [7:0]  bus_bytes;
        logic [15:0] factor;
        logic [31:0] unit;
        logic [13:0] fixed_vote;
        logic [31:0] threshold;
        logic        commit;
    } vote_req_t;

    typedef struct {
        vote_req_t   req;
        logic        known;     // expected word typed in
        logic [31:0] word;
    } vote_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [31:0] expected_words[$];
    vote_req_t   req_q[$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          faults_seen = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always #1 aclk = ~aclk;

    bus_bandwidth_vote_encoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [31:0] encode_vote(vote_req_t r);
        logic [63:0] peak;
        logic [13:0] vote;
        vote = '0;
        if (r.bw != 0 && r.fixed_vote != 0) begin
            if (r.bw >= r.threshold)
                vote = r.fixed_vote;
        end else if (r.bw != 0) begin
            if (r.unit == 0 || r.bus_bytes == 0)
                return {1'b1, 31'd0};
            peak = 64'(r.bw) * 64'(r.factor);
            peak = peak / 64'(r.bus_bytes);
            peak = (peak * 64'd1000) / 64'(r.unit);
            vote = (peak > 64'(VOTE_MAX)) ? VOTE_MAX : peak[13:0];
            if (vote == 0)
                vote = 14'd1;
        end
        return {1'b0, r.commit, r.bw != 0, 1'b0, vote, vote};
    endfunction

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(1, 255);
            3: return $urandom_range(1, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic vote_req_t random_req();
        vote_req_t r;
        r.bw         = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_wide();
        r.bus_bytes  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        r.factor     = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 16'hffff)
                                                   : 16'($urandom);
        r.unit       = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_wide();
        if (r.unit == 0 && $urandom_range(0, 1))
            r.unit = $urandom_range(1, 4000);
        r.fixed_vote = ($urandom_range(0, 2) == 0) ? 14'($urandom) : 14'd0;
        r.threshold  = ($urandom_range(0, 1)) ? r.bw + 32'($urandom_range(0, 2)) - 32'd1
                                              : pick_wide();
        r.commit     = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_req(vote_req_t r);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {2'b00, r.threshold, r.fixed_vote, r.unit, r.factor, r.bus_bytes, r.bw};
        s_tlast  <= r.commit;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold the expectation queue in order of acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_words.push_back(encode_vote(req_q.pop_front()));
    end

    always @(posedge aclk) begin
        logic [31:0] exp_word;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (m_tdata[31]) faults_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: unexpected command word %h", m_tdata);
            end else begin
                exp_word = expected_words.pop_front();
                if (m_tdata[30:0] !== exp_word[30:0] || m_tdata[31] !== exp_word[31]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb: word %0d expected fault %b word %h, got fault %b word %h",
                                 words_seen, exp_word[31], exp_word[30:0],
                                 m_tdata[31], m_tdata[30:0]);
                end
            end
        end
    end

    // random backpressure on the result side
    always @(negedge aclk) begin
        int p;
        p = $urandom_range(0, 99);
        if (!aresetn) m_tready <= 1'b0;
        else if (stim_done && expected_words.size() == 0) m_tready <= 1'b1;
        else if (p < 70) m_tready <= 1'b1;
        else if (p < 97) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired, %0d requests outstanding", expected_words.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    vote_row_t table_rows[$];

    function automatic vote_req_t mk(logic [31:0] bw, logic [7:0] bwid, logic [15:0] f,
                                     logic [31:0] u, logic [13:0] fv, logic [31:0] th,
                                     logic c);
        vote_req_t r;
        r = '{bw, bwid, f, u, fv, th, c};
        return r;
    endfunction

    task automatic add_row(vote_req_t r, logic known, logic [31:0] word);
        vote_row_t row;
        row.req = r; row.known = known; row.word = word;
        table_rows.push_back(row);
    endtask

    initial begin
        vote_req_t r;
        add_row(mk(0, 0, 0, 0, 0, 0, 1), 1, 32'h4000_0000);                       // off level
        add_row(mk(0, 0, 16'hffff, 0, 0, 0, 0), 1, 32'h0000_0000);
        add_row(mk(100, 0, 1, 1000, 0, 0, 1), 1, 32'h8000_0000);                  // zero bus width
        add_row(mk(100, 4, 1, 0, 0, 0, 1), 1, 32'h8000_0000);                     // zero unit
        add_row(mk(32'hffffffff, 255, 16'hffff, 32'hffffffff, 0, 0, 1), 0, '0);
        add_row(mk(32'hffffffff, 1, 16'hffff, 1, 0, 0, 1), 1, 32'h6fff_ffff);      // saturate
        add_row(mk(1, 255, 1, 32'hffffffff, 0, 0, 0), 1, 32'h2000_4001);           // floor at one
        add_row(mk(1, 1, 0, 1, 0, 0, 0), 1, 32'h2000_4001);
        add_row(mk(5, 1, 1, 1000, 14'h3fff, 5, 1), 1, 32'h6fff_ffff);              // fixed at threshold
        add_row(mk(4, 1, 1, 1000, 14'h3fff, 5, 1), 1, 32'h6000_0000);              // fixed below
        add_row(mk(7, 0, 0, 0, 14'd1, 32'hffffffff, 0), 1, 32'h2000_0000);
        add_row(mk(32'hffffffff, 0, 0, 0, 14'd1, 32'hffffffff, 0), 1, 32'h2000_4001);
        add_row(mk(1000, 8, 16'd16, 32'd1000, 0, 0, 1), 0, '0);
        add_row(mk(32'h12345678, 8'h5a, 16'ha5a5, 32'h0f0f0f0f, 0, 32'h55555555, 0), 0, '0);
        add_row(mk(32'hedcba987, 8'ha5, 16'h5a5a, 32'hf0f0f0f0, 14'h2aaa, 32'haaaaaaaa, 1), 0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (table_rows[i]) begin
            r = table_rows[i].req;
            if (table_rows[i].known && encode_vote(r) !== table_rows[i].word) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: row %0d predictor %h, table %h", i, encode_vote(r),
                             table_rows[i].word);
            end
            req_q.push_back(r);
            send_req(r);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            r = random_req();
            req_q.push_back(r);
            send_req(r);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("tb: %0d requests sent, %0d command words checked, %0d with fault",
                 table_rows.size() + N_RANDOM, words_seen, faults_seen);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
